// ----- design/tqla_pkg.sv -----
// shared constants, codes and types of the tabular q-learning agent
package tqla_pkg;

   localparam int NUM_STATES_DEF  = 256;
   localparam int NUM_ACTIONS_DEF = 4;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int FRAC_BITS   = 16;
   localparam int COEF_W      = 16;
   localparam int THRESH_W    = 17;
   localparam int REWARD_W    = 32;
   localparam int RSUM_W      = 48;
   localparam int COUNT_W     = 32;
   localparam int STATE_IDX_W = 8;
   localparam int ACTION_W    = 2;
   localparam int DRAW_W      = 16;
   localparam int OPCODE_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_FIELD_W = ACTION_W + 1 + COUNT_W + RSUM_W + COUNT_W;
   localparam int RSP_TDATA_W = 120;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   localparam logic [OPCODE_W-1:0] OP_DECIDE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TRAIN  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEARN_RATE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISCOUNT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPLORE    = 2'd2;

   localparam logic [COEF_W-1:0]   LEARN_RATE_RST = 16'd13107;
   localparam logic [COEF_W-1:0]   DISCOUNT_RST   = 16'd58982;
   localparam logic [THRESH_W-1:0] EXPLORE_RST    = 17'd6554;

   typedef struct packed {
      logic              start;
      logic [COEF_W-1:0] coef;
   } scale_req_type;

endpackage

// ----- design/tqla_ram.sv -----
// generic single write port ram with registered read
module tqla_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/tqla_scale.sv -----
// shared multi-cycle scaler: floor(coef * operand / 2^16) over two partial products
module tqla_scale #(
   parameter int DIFF_W = 34
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tqla_pkg::scale_req_type     cmd,
   input  logic signed [DIFF_W-1:0]    operand,
   output logic                        done,
   output logic signed [DIFF_W-1:0]    result
);

   import tqla_pkg::*;

   localparam int LO_W   = (DIFF_W + 1) / 2;
   localparam int MB_W   = LO_W + 1;
   localparam int PROD_W = COEF_W + 1 + MB_W;
   localparam int ACC_W  = DIFF_W + COEF_W + 1;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LO   = 2'd1;
   localparam logic [1:0] PH_HI   = 2'd2;
   localparam logic [1:0] PH_ACC  = 2'd3;

   logic [1:0]               ph_ff, ph_in;
   logic                     done_ff, done_in;
   logic [COEF_W-1:0]        coef_ff, coef_in;
   logic signed [DIFF_W-1:0] opnd_ff, opnd_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [MB_W-1:0]   lo_ext, hi_ext, mul_b;

   always_comb begin
      lo_ext  = $signed({1'b0, opnd_ff[LO_W-1:0]});
      hi_ext  = MB_W'($signed(opnd_ff[DIFF_W-1:LO_W]));
      mul_b   = (ph_ff == PH_LO) ? lo_ext : hi_ext;
      prod_in = $signed({1'b0, coef_ff}) * mul_b;

      ph_in   = ph_ff;
      done_in = 1'b0;
      coef_in = coef_ff;
      opnd_in = opnd_ff;
      acc_in  = acc_ff;

      unique case (ph_ff)
         PH_IDLE: begin
            if (cmd.start) begin
               coef_in = cmd.coef;
               opnd_in = operand;
               ph_in   = PH_LO;
            end
         end
         PH_LO: begin
            ph_in = PH_HI;
         end
         PH_HI: begin
            acc_in = ACC_W'(prod_ff);
            ph_in  = PH_ACC;
         end
         PH_ACC: begin
            acc_in  = acc_ff + (ACC_W'(prod_ff) <<< LO_W);
            done_in = 1'b1;
            ph_in   = PH_IDLE;
         end
         default: begin
            ph_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= done_in;
      end
      coef_ff <= coef_in;
      opnd_ff <= opnd_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done   = done_ff;
   assign result = DIFF_W'(acc_ff >>> FRAC_BITS);

endmodule

// ----- design/tabular_q_learning_agent.sv -----
// top level of the tabular q-learning agent with epsilon-greedy choice
//
//  channel | direction | handshake            | content
//  req     | in        | req_tvalid/tready    | one request item (opcode in tuser, done in tlast)
//  rsp     | out       | rsp_tvalid/tready    | one result item per request
//  csr     | in        | csr_valid/csr_ready  | register index and write data
//
//  explore decide, clear and unused opcodes go straight to the result; exploit decide scans
//  the row; train scans the next row, skipped on the last step of an episode; the row scan reads one
//  table entry a cycle and both multiplies share one two-pass scaler
//  state indices at or above NUM_STATES are reduced by repeated subtraction of NUM_STATES
//  after reset a clearing pass writes zero to all NUM_STATES * 2^clog2(NUM_ACTIONS)
//  entries, one a cycle, with req_tready low; register writes are always taken
//  a finished result waits in the output register while the next item is accepted
module tabular_q_learning_agent #(
   parameter int NUM_STATES  = tqla_pkg::NUM_STATES_DEF,
   parameter int NUM_ACTIONS = tqla_pkg::NUM_ACTIONS_DEF,
   parameter int VALUE_WIDTH = tqla_pkg::VALUE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // state_index, next_state_index, taken_action, reward, random_draw, random_action
   input  logic [tqla_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // opcode
   input  logic [tqla_pkg::OPCODE_W-1:0]     req_tuser,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // chosen_action, explored, steps_taken, reward_sum, episodes_done
   output logic [tqla_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tqla_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tqla_pkg::CSR_DATA_W-1:0]   csr_data
);

   import tqla_pkg::*;

   localparam int SIDX_W   = $clog2(NUM_STATES);
   localparam int ACT_W    = $clog2(NUM_ACTIONS);
   localparam int ADDR_W   = SIDX_W + ACT_W;
   localparam int DEPTH    = NUM_STATES * (2 ** ACT_W);
   localparam int WIDE_W   = (VALUE_WIDTH > REWARD_W) ? VALUE_WIDTH : REWARD_W;
   localparam int DIFF_W   = WIDE_W + 2;
   localparam int QSUM_W   = DIFF_W + 1;

   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic [ACT_W-1:0]  ACT_LAST = ACT_W'(NUM_ACTIONS - 1);
   localparam logic signed [QSUM_W-1:0] QMAX =
      {{(QSUM_W - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
   localparam logic signed [QSUM_W-1:0] QMIN = ~QMAX;
   localparam logic [RSUM_W-1:0] RSUM_MAX = {1'b0, {(RSUM_W - 1){1'b1}}};
   localparam logic [RSUM_W-1:0] RSUM_MIN = {1'b1, {(RSUM_W - 1){1'b0}}};

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_REDUCE = 4'd2;
   localparam logic [3:0] ST_SCAN   = 4'd3;
   localparam logic [3:0] ST_DRAIN  = 4'd4;
   localparam logic [3:0] ST_READQ  = 4'd5;
   localparam logic [3:0] ST_QWAIT  = 4'd6;
   localparam logic [3:0] ST_GAMMA  = 4'd7;
   localparam logic [3:0] ST_DIFF   = 4'd8;
   localparam logic [3:0] ST_ALPHA  = 4'd9;
   localparam logic [3:0] ST_WRITE  = 4'd10;
   localparam logic [3:0] ST_FINISH = 4'd11;

   logic [3:0]                    state_ff, state_in;
   logic [ADDR_W-1:0]             clr_ff, clr_in;
   logic [OPCODE_W-1:0]           op_ff, op_in;
   logic [STATE_IDX_W-1:0]        s_ff, s_in, ns_ff, ns_in;
   logic [ACTION_W-1:0]           act_ff, act_in;
   logic signed [REWARD_W-1:0]    rew_ff, rew_in;
   logic                          epdone_ff, epdone_in;
   logic [ACT_W-1:0]              scan_ff, scan_in;
   logic                          cmp_vld_ff, cmp_vld_in;
   logic [ACT_W-1:0]              cmp_idx_ff, cmp_idx_in;
   logic signed [VALUE_WIDTH-1:0] best_val_ff, best_val_in;
   logic [ACT_W-1:0]              best_idx_ff, best_idx_in;
   logic signed [VALUE_WIDTH-1:0] q_ff, q_in;
   logic signed [DIFF_W-1:0]      tgt_ff, tgt_in;
   logic signed [QSUM_W-1:0]      qsum_ff, qsum_in;
   logic [COUNT_W-1:0]            steps_ff, steps_in, eps_ff, eps_in;
   logic [RSUM_W-1:0]             rsum_ff, rsum_in;
   logic [ACTION_W-1:0]           res_act_ff, res_act_in;
   logic                          res_exp_ff, res_exp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [COEF_W-1:0]             alpha_ff, gamma_ff;
   logic [THRESH_W-1:0]           thresh_ff;

   logic [STATE_IDX_W-1:0]        in_state, in_next;
   logic [ACTION_W-1:0]           in_act, in_rand_act, act_red;
   logic signed [REWARD_W-1:0]    in_reward;
   logic [DRAW_W-1:0]             in_draw;
   logic                          accept, explore, s_big, ns_big;
   logic signed [RSUM_W:0]        rsum_wide;
   logic [RSUM_W-1:0]             rsum_sat;
   logic [SIDX_W-1:0]             s_idx, ns_idx, row_idx;
   logic [ACT_W-1:0]              a_idx;
   logic signed [VALUE_WIDTH-1:0] rd_val, q_sat;

   logic                          ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]             ram_wr_addr, ram_rd_addr;
   logic [VALUE_WIDTH-1:0]        ram_wr_data, ram_rd_data;

   scale_req_type                 sc_cmd;
   logic signed [DIFF_W-1:0]      sc_opnd, sc_result;
   logic                          sc_done;

   tqla_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tqla_scale #(
      .DIFF_W (DIFF_W)
   ) u_scale (
      .clock   (clock),
      .reset   (reset),
      .cmd     (sc_cmd),
      .operand (sc_opnd),
      .done    (sc_done),
      .result  (sc_result)
   );

   assign in_state    = req_tdata[7:0];
   assign in_next     = req_tdata[15:8];
   assign in_act      = req_tdata[17:16];
   assign in_reward   = $signed(req_tdata[49:18]);
   assign in_draw     = req_tdata[65:50];
   assign in_rand_act = req_tdata[67:66];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      act_red   = (32'(in_act) >= NUM_ACTIONS) ? (in_act - 2'(NUM_ACTIONS)) : in_act;
      explore   = ({1'b0, in_draw} < thresh_ff);
      rsum_wide = (RSUM_W + 1)'($signed(rsum_ff)) + (RSUM_W + 1)'(in_reward);
      if (rsum_wide[RSUM_W] != rsum_wide[RSUM_W-1]) begin
         rsum_sat = rsum_wide[RSUM_W] ? RSUM_MIN : RSUM_MAX;
      end else begin
         rsum_sat = rsum_wide[RSUM_W-1:0];
      end

      s_big   = (32'(s_ff) >= NUM_STATES);
      ns_big  = (32'(ns_ff) >= NUM_STATES);
      s_idx   = SIDX_W'(s_ff);
      ns_idx  = SIDX_W'(ns_ff);
      a_idx   = ACT_W'(act_ff);
      row_idx = (op_ff == OP_DECIDE) ? s_idx : ns_idx;
      rd_val  = $signed(ram_rd_data);

      if (qsum_ff > QMAX) begin
         q_sat = VALUE_WIDTH'(QMAX);
      end else if (qsum_ff < QMIN) begin
         q_sat = VALUE_WIDTH'(QMIN);
      end else begin
         q_sat = VALUE_WIDTH'(qsum_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      s_in         = s_ff;
      ns_in        = ns_ff;
      act_in       = act_ff;
      rew_in       = rew_ff;
      epdone_in    = epdone_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      q_in         = q_ff;
      tgt_in       = tgt_ff;
      qsum_in      = qsum_ff;
      steps_in     = steps_ff;
      eps_in       = eps_ff;
      rsum_in      = rsum_ff;
      res_act_in   = res_act_ff;
      res_exp_in   = res_exp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = {s_idx, a_idx};
      ram_wr_data  = q_sat;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = {row_idx, scan_ff};
      sc_cmd.start = 1'b0;
      sc_cmd.coef  = gamma_ff;
      sc_opnd      = epdone_ff ? '0 : DIFF_W'(best_val_ff);

      best_val_in = best_val_ff;
      best_idx_in = best_idx_ff;
      if (cmp_vld_ff && ((cmp_idx_ff == '0) || (rd_val > best_val_ff))) begin
         best_val_in = rd_val;
         best_idx_in = cmp_idx_ff;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_tuser;
               s_in       = in_state;
               ns_in      = in_next;
               act_in     = act_red;
               rew_in     = in_reward;
               epdone_in  = req_tlast;
               res_act_in = '0;
               res_exp_in = 1'b0;
               unique case (req_tuser)
                  OP_DECIDE: begin
                     if (steps_ff != '1) begin
                        steps_in = steps_ff + 1'b1;
                     end
                     if (explore) begin
                        res_act_in = in_rand_act;
                        res_exp_in = 1'b1;
                        state_in   = ST_FINISH;
                     end else begin
                        state_in = ST_REDUCE;
                     end
                  end
                  OP_TRAIN: begin
                     rsum_in = rsum_sat;
                     if (req_tlast && (eps_ff != '1)) begin
                        eps_in = eps_ff + 1'b1;
                     end
                     state_in = ST_REDUCE;
                  end
                  OP_CLEAR: begin
                     steps_in = '0;
                     rsum_in  = '0;
                     state_in = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_REDUCE: begin
            if (s_big) begin
               s_in = s_ff - 8'(NUM_STATES);
            end
            if (ns_big) begin
               ns_in = ns_ff - 8'(NUM_STATES);
            end
            if (!s_big && !ns_big) begin
               scan_in = '0;
               if ((op_ff == OP_DECIDE) || !epdone_ff) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_READQ;
               end
            end
         end
         ST_SCAN: begin
            ram_rd_en  = 1'b1;
            cmp_vld_in = 1'b1;
            cmp_idx_in = scan_ff;
            scan_in    = scan_ff + 1'b1;
            if (scan_ff == ACT_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (op_ff == OP_DECIDE) begin
               res_act_in = ACTION_W'(best_idx_in);
               state_in   = ST_FINISH;
            end else begin
               state_in = ST_READQ;
            end
         end
         ST_READQ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = {s_idx, a_idx};
            state_in    = ST_QWAIT;
         end
         ST_QWAIT: begin
            q_in         = rd_val;
            sc_cmd.start = 1'b1;
            state_in     = ST_GAMMA;
         end
         ST_GAMMA: begin
            if (sc_done) begin
               tgt_in   = DIFF_W'(rew_ff) + sc_result;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            sc_cmd.start = 1'b1;
            sc_cmd.coef  = alpha_ff;
            sc_opnd      = tgt_ff - DIFF_W'(q_ff);
            state_in     = ST_ALPHA;
         end
         ST_ALPHA: begin
            if (sc_done) begin
               qsum_in  = QSUM_W'(q_ff) + QSUM_W'(sc_result);
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_wr_en = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, eps_ff, rsum_ff, steps_ff,
                               res_exp_ff, res_act_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         steps_ff     <= '0;
         eps_ff       <= '0;
         rsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         alpha_ff     <= LEARN_RATE_RST;
         gamma_ff     <= DISCOUNT_RST;
         thresh_ff    <= EXPLORE_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cmp_vld_ff   <= cmp_vld_in;
         steps_ff     <= steps_in;
         eps_ff       <= eps_in;
         rsum_ff      <= rsum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_LEARN_RATE: alpha_ff  <= csr_data[COEF_W-1:0];
               CSR_DISCOUNT:   gamma_ff  <= csr_data[COEF_W-1:0];
               CSR_EXPLORE:    thresh_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
      op_ff       <= op_in;
      s_ff        <= s_in;
      ns_ff       <= ns_in;
      act_ff      <= act_in;
      rew_ff      <= rew_in;
      epdone_ff   <= epdone_in;
      scan_ff     <= scan_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
      q_ff        <= q_in;
      tgt_ff      <= tgt_in;
      qsum_ff     <= qsum_in;
      res_act_ff  <= res_act_in;
      res_exp_ff  <= res_exp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- tb/sv/tabular_q_learning_agent_tb.sv -----
// testbench for the tabular q-learning agent: random and directed requests checked against a predictor
`timescale 1ns / 100ps

module tabular_q_learning_agent_tb;
   import tqla_pkg::*;

   typedef struct {
      bit [OPCODE_W-1:0]        opcode;
      bit [STATE_IDX_W-1:0]     state_idx;
      bit [STATE_IDX_W-1:0]     next_idx;
      bit [ACTION_W-1:0]        action;
      bit signed [REWARD_W-1:0] reward;
      bit                       done;
      bit [DRAW_W-1:0]          draw;
      bit [ACTION_W-1:0]        rand_action;
   } agent_req_type;

   typedef struct {
      bit [ACTION_W-1:0] action;
      bit                explored;
      bit [COUNT_W-1:0]  steps;
      bit [RSUM_W-1:0]   reward_sum;
      bit [COUNT_W-1:0]  episodes;
   } agent_rsp_type;

   class q_agent_scoreboard;
      longint            q_table [NUM_STATES_DEF][NUM_ACTIONS_DEF];
      bit [COUNT_W-1:0]  step_count;
      longint            reward_total;
      bit [COUNT_W-1:0]  episode_count;
      bit [COEF_W-1:0]   learn_rate = LEARN_RATE_RST;
      bit [COEF_W-1:0]   discount = DISCOUNT_RST;
      bit [THRESH_W-1:0] explore_threshold = EXPLORE_RST;
      agent_rsp_type     answers_due [$];
      int                failures;

      function longint saturate(longint v, int width);
         longint hi, lo;
         hi = (longint'(1) << (width - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function void set_register(bit [CSR_INDEX_W-1:0] idx, bit [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_LEARN_RATE: learn_rate = data[COEF_W-1:0];
            CSR_DISCOUNT:   discount = data[COEF_W-1:0];
            CSR_EXPLORE:    explore_threshold = data[THRESH_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(agent_req_type r);
         agent_rsp_type a;
         int            best;
         longint        best_next, q, target, rw;
         a = '{default: 0};
         case (r.opcode)
            OP_DECIDE: begin
               if (step_count != '1) step_count++;
               if ({1'b0, r.draw} < explore_threshold) begin
                  a.action = r.rand_action;
                  a.explored = 1'b1;
               end else begin
                  best = 0;
                  for (int i = 1; i < NUM_ACTIONS_DEF; i++)
                     if (q_table[r.state_idx][i] > q_table[r.state_idx][best]) best = i;
                  a.action = ACTION_W'(best);
               end
            end
            OP_TRAIN: begin
               rw = longint'(r.reward);
               best_next = 0;
               if (!r.done) begin
                  best_next = q_table[r.next_idx][0];
                  for (int i = 1; i < NUM_ACTIONS_DEF; i++)
                     if (q_table[r.next_idx][i] > best_next) best_next = q_table[r.next_idx][i];
               end
               q = q_table[r.state_idx][r.action];
               target = rw + ((longint'(discount) * best_next) >>> FRAC_BITS);
               q_table[r.state_idx][r.action] =
                  saturate(q + ((longint'(learn_rate) * (target - q)) >>> FRAC_BITS),
                           VALUE_WIDTH_DEF);
               reward_total = saturate(reward_total + rw, RSUM_W);
               if (r.done && episode_count != '1) episode_count++;
            end
            OP_CLEAR: begin
               step_count = 0;
               reward_total = 0;
            end
            default: ;
         endcase
         a.steps = step_count;
         a.reward_sum = reward_total[RSUM_W-1:0];
         a.episodes = episode_count;
         answers_due.push_back(a);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] d);
         agent_rsp_type want;
         if (answers_due.size() == 0) begin
            $error("result item with none expected: 0x%0h", d);
            failures++;
            return;
         end
         want = answers_due.pop_front();
         compare_field("chosen_action", 64'(want.action), 64'(d[1:0]));
         compare_field("explored", 64'(want.explored), 64'(d[2]));
         compare_field("steps_taken", 64'(want.steps), 64'(d[34:3]));
         compare_field("reward_sum", 64'(want.reward_sum), 64'(d[82:35]));
         compare_field("episodes_done", 64'(want.episodes), 64'(d[114:83]));
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic [REQ_TDATA_W-1:0]      req_tdata;
   logic [OPCODE_W-1:0]         req_tuser;
   logic                        req_tlast;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [RSP_TDATA_W-1:0]      rsp_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]       csr_data;

   q_agent_scoreboard sb;
   bit                steady;
   int                rsp_hold;

   tabular_q_learning_agent dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int idle_gap();
      int p;
      if (steady) return 0;
      p = $urandom_range(0, 99);
      if (p < 65) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold <= idle_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   function automatic agent_req_type make_req(bit [1:0] op, bit [7:0] s, bit [7:0] ns,
                                              bit [1:0] a, bit [31:0] rw, bit done,
                                              bit [15:0] draw, bit [1:0] ra);
      agent_req_type r;
      r.opcode = op;
      r.state_idx = s;
      r.next_idx = ns;
      r.action = a;
      r.reward = rw;
      r.done = done;
      r.draw = draw;
      r.rand_action = ra;
      return r;
   endfunction

   function automatic bit [7:0] pick_state();
      if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 7));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic agent_req_type random_req();
      agent_req_type r;
      int            p;
      bit [31:0]     rw;
      p = $urandom_range(0, 99);
      case ($urandom_range(0, 4))
         0, 1: rw = $urandom();
         2: rw = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: rw = $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                            : -$urandom_range(0, 1 << 20);
      endcase
      r = make_req(p < 48 ? OP_TRAIN : p < 95 ? OP_DECIDE : p < 98 ? OP_CLEAR : OP_UNUSED,
                   pick_state(), pick_state(), 2'($urandom_range(0, 3)), rw,
                   $urandom_range(0, 4) == 0, 16'($urandom_range(0, 65535)),
                   2'($urandom_range(0, 3)));
      return r;
   endfunction

   task automatic send_request(agent_req_type r);
      int gap;
      req_tdata <= {4'b0, r.rand_action, r.draw, r.reward, r.action, r.next_idx, r.state_idx};
      req_tuser <= r.opcode;
      req_tlast <= r.done;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
      @(negedge clock);
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.answers_due.size() != 0);
   endtask

   task automatic write_csr(bit [CSR_INDEX_W-1:0] idx, bit [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, data);
      @(negedge clock);
   endtask

   task automatic apply_settings(bit [15:0] alpha, bit [15:0] gamma, bit [16:0] eps);
      write_csr(CSR_LEARN_RATE, CSR_DATA_W'(alpha));
      write_csr(CSR_DISCOUNT, CSR_DATA_W'(gamma));
      write_csr(CSR_EXPLORE, eps);
      csr_valid <= 1'b0;
   endtask

   initial begin
      agent_req_type directed [$];
      sb = new;
      clock = 1'b0;
      reset = 1'b1;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      req_tvalid = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      rsp_hold = 0;
      steady = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values of the registers are in force here
      directed.push_back(make_req(OP_DECIDE, 0, 0, 0, 0, 0, 16'hffff, 0));
      directed.push_back(make_req(OP_DECIDE, 255, 0, 0, 0, 0, 0, 3));
      directed.push_back(make_req(OP_DECIDE, 9, 0, 0, 0, 0, 6553, 2));
      directed.push_back(make_req(OP_DECIDE, 9, 0, 0, 0, 0, 6554, 2));
      directed.push_back(make_req(OP_TRAIN, 0, 1, 3, 32'h7fff_ffff, 0, 0, 0));
      directed.push_back(make_req(OP_TRAIN, 0, 0, 3, 32'h7fff_ffff, 0, 0, 0));
      directed.push_back(make_req(OP_TRAIN, 0, 0, 3, 32'h7fff_ffff, 0, 0, 0));
      directed.push_back(make_req(OP_TRAIN, 255, 0, 2, 32'h8000_0000, 1, 0, 0));
      directed.push_back(make_req(OP_TRAIN, 255, 255, 1, 32'h8000_0000, 0, 0, 0));
      directed.push_back(make_req(OP_DECIDE, 0, 0, 0, 0, 0, 16'hffff, 1));
      directed.push_back(make_req(OP_DECIDE, 255, 0, 0, 0, 0, 16'hffff, 1));
      directed.push_back(make_req(OP_TRAIN, 5, 6, 1, 100 << 16, 0, 0, 0));
      directed.push_back(make_req(OP_TRAIN, 5, 6, 2, 100 << 16, 0, 0, 0));
      directed.push_back(make_req(OP_DECIDE, 5, 0, 0, 0, 0, 40000, 0));
      directed.push_back(make_req(OP_TRAIN, 6, 5, 0, -1, 1, 0, 0));
      directed.push_back(make_req(OP_UNUSED, 8'hff, 8'hff, 3, '1, 1, 16'hffff, 3));
      directed.push_back(make_req(OP_CLEAR, 8'hff, 8'hff, 3, '1, 1, 16'hffff, 3));
      directed.push_back(make_req(OP_DECIDE, 3, 0, 0, 0, 0, 1, 1));
      directed.push_back(make_req(OP_TRAIN, 8'hff, 8'hff, 3, '1, 1, 16'hffff, 3));
      directed.push_back(make_req(OP_TRAIN, 0, 255, 0, 0, 0, 0, 0));
      directed.push_back(make_req(OP_DECIDE, 0, 0, 0, 0, 0, 16'hffff, 0));
      foreach (directed[i]) send_request(directed[i]);

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            1: apply_settings(16'hffff, 16'hffff, 17'd0);
            2: apply_settings(16'd0, 16'd0, 17'd65536);
            3: apply_settings(16'hffff, 16'd0, 17'h1ffff);
            4: apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              17'($urandom_range(0, 65536)));
            5: apply_settings(16'd1, 16'hffff, 17'd32768);
            default: ;
         endcase
         steady = (phase % 3 == 1);
         for (int n = 0; n < 320; n++) begin
            if (phase == 2 && n == 160) drain();
            send_request(random_req());
         end
      end
      drain();
      steady = 1'b0;
      repeat (40) @(posedge clock);
      if (sb.failures == 0)
         $display("tabular_q_learning_agent_tb: PASS");
      else
         $display("tabular_q_learning_agent_tb: FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tabular_q_learning_agent_tb: FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/tqla_pkg.sv
design/tqla_ram.sv
design/tqla_scale.sv
design/tabular_q_learning_agent.sv
tb/sv/tabular_q_learning_agent_tb.sv
